// ===== hw/rtl/pief_pkg.sv =====
// Package for the polynomial implicit function evaluator.
// Holds widths, register indexes, state codes and the structs shared by
// the register file, controller and datapath. No dependencies.
package pief_pkg;

  localparam int SPACE_DIM     = 3;
  localparam int MAX_TERMS     = 6;
  localparam int MAX_POWER     = 15;
  localparam int NUM_TERM_REGS = 6;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int VAL_W   = 48;
  localparam int POW_W   = 4;
  localparam int TERM_W  = COORD_W + 3 * POW_W;
  localparam int CNT_W   = 3;

  // register file addressing: 64-bit registers at 8-byte strides
  localparam int NUM_REGS  = 2 + NUM_TERM_REGS;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int ADDR_W    = REG_IDX_W + 3;
  localparam int DATA_W    = 64;

  localparam logic [REG_IDX_W-1:0] REG_INSIDE = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_COUNT  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_TERM0  = REG_IDX_W'(2);

  // counters and selects
  localparam int TIDX_W = (NUM_TERM_REGS > 1) ? $clog2(NUM_TERM_REGS) : 1;
  localparam int TCNT_W = $clog2(MAX_TERMS + 1);
  localparam int DIDX_W = (SPACE_DIM > 1) ? $clog2(SPACE_DIM) : 1;
  localparam int DCNT_W = $clog2(SPACE_DIM + 1);

  // split multiply: 48-bit running value times 32-bit coordinate
  localparam int HALF_W = VAL_W / 2;
  localparam int PART_W = HALF_W + 1 + COORD_W;
  localparam int FULL_W = VAL_W + COORD_W;
  localparam int SHR_W  = FULL_W - FRAC_W;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic                                   inside_flag;
    logic [CNT_W-1:0]                       term_count;
    logic [NUM_TERM_REGS-1:0][TERM_W-1:0]   term_word;
  } cfg_t;

  typedef struct packed {
    logic              load_point;
    logic              load_coef;
    logic              mul_lo;
    logic              mul_hi;
    logic              fold;
    logic              accum;
    logic              negate;
    logic [TIDX_W-1:0] term_sel;
    logic [DIDX_W-1:0] dim_sel;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM,
    ST_DIM,
    ST_STEP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FOLD,
    ST_ACCUM,
    ST_NEGATE,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/polynomial_implicit_function_eval.sv =====
// Sparse 3-D polynomial evaluator in signed Q16.16 fixed point.
// Instantiates pief_regs, pief_ctrl and pief_dpath; uses pief_pkg.
//
// Usage:
//   Configure inside_flag, term_count and term_word_0..5 over the APB port
//   (64-bit registers at byte address 8*index) while the block is idle.
//   Present a point on point_x/y/z and raise start; the item is taken on the
//   rising edge where start is high and busy is low. busy stays high until
//   the result is out.
//   The result appears on func_value/overflow for exactly one cycle with
//   done high; there is no back pressure, the receiver must take it then.
// Sequencing:
//   Each Q16.16 multiply goes through the one 25x32 multiplier in two
//   passes (ST_MUL_LO, ST_MUL_HI) plus a fold/saturate step (ST_FOLD),
//   with a step check (ST_STEP).
//   One item at a time; a new start is taken the cycle after done.
// Reset:
//   Synchronous rst returns the sequencer to idle, sets inside_flag to 1
//   and clears term_count and the term words; datapath registers are not reset.
module polynomial_implicit_function_eval (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [pief_pkg::COORD_W-1:0]   point_x,
  input  logic signed [pief_pkg::COORD_W-1:0]   point_y,
  input  logic signed [pief_pkg::COORD_W-1:0]   point_z,
  output logic                                  done,
  output logic signed [pief_pkg::VAL_W-1:0]     func_value,
  output logic                                  overflow,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pief_pkg::ADDR_W-1:0]           paddr,
  input  logic [pief_pkg::DATA_W-1:0]           pwdata,
  output logic [pief_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);

  pief_pkg::cfg_t cfg;
  pief_pkg::cmd_t cmd;

  pief_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pief_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cfg   (cfg),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  pief_dpath u_dpath (
    .clk        (clk),
    .cmd        (cmd),
    .cfg        (cfg),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .func_value (func_value),
    .overflow   (overflow)
  );

endmodule

// ===== hw/rtl/pief_regs.sv =====
// Configuration register file with an APB-style port.
// Depends on pief_pkg for widths, register indexes and cfg_t.
module pief_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pief_pkg::ADDR_W-1:0]   paddr,
  input  logic [pief_pkg::DATA_W-1:0]   pwdata,
  output logic [pief_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output pief_pkg::cfg_t                cfg
);

  logic [pief_pkg::REG_IDX_W-1:0] idx;
  logic [pief_pkg::REG_IDX_W-1:0] term_off;
  logic                           wr_en;

  assign pready   = 1'b1;
  assign idx      = paddr[pief_pkg::ADDR_W-1:3];
  assign term_off = idx - pief_pkg::REG_TERM0;
  assign wr_en    = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inside_flag <= 1'b1;
      cfg.term_count  <= '0;
      cfg.term_word   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        pief_pkg::REG_INSIDE: cfg.inside_flag <= pwdata[0];
        pief_pkg::REG_COUNT:  cfg.term_count  <= pwdata[pief_pkg::CNT_W-1:0];
        default: begin
          cfg.term_word[term_off[pief_pkg::TIDX_W-1:0]] <= pwdata[pief_pkg::TERM_W-1:0];
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      pief_pkg::REG_INSIDE: prdata[0] = cfg.inside_flag;
      pief_pkg::REG_COUNT:  prdata[pief_pkg::CNT_W-1:0] = cfg.term_count;
      default: begin
        prdata[pief_pkg::TERM_W-1:0] = cfg.term_word[term_off[pief_pkg::TIDX_W-1:0]];
      end
    endcase
  end

endmodule

// ===== hw/rtl/pief_ctrl.sv =====
// Sequencer: walks terms, coordinates and powers, issuing datapath commands.
// Depends on pief_pkg for state_t, cmd_t and cfg_t.
module pief_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pief_pkg::cfg_t cfg,
  output logic           busy,
  output logic           done,
  output pief_pkg::cmd_t cmd
);

  pief_pkg::state_t state, state_next;

  logic [pief_pkg::TCNT_W-1:0] term_idx;
  logic [pief_pkg::DCNT_W-1:0] dim_idx;
  logic [pief_pkg::POW_W-1:0]  pcnt;

  logic [pief_pkg::TCNT_W-1:0] n_terms;
  logic [pief_pkg::TERM_W-1:0] word;
  logic [pief_pkg::POW_W-1:0]  pow_arr [pief_pkg::SPACE_DIM];
  logic [pief_pkg::POW_W-1:0]  pw_raw;
  logic [pief_pkg::POW_W-1:0]  pw;
  logic                        terms_done;
  logic                        dims_done;

  assign n_terms = (32'(cfg.term_count) > pief_pkg::MAX_TERMS) ?
                   pief_pkg::TCNT_W'(pief_pkg::MAX_TERMS) :
                   pief_pkg::TCNT_W'(cfg.term_count);
  assign word    = cfg.term_word[term_idx[pief_pkg::TIDX_W-1:0]];

  always_comb begin
    for (int d = 0; d < pief_pkg::SPACE_DIM; d++) begin
      pow_arr[d] = word[pief_pkg::COORD_W + pief_pkg::POW_W*d +: pief_pkg::POW_W];
    end
  end

  assign pw_raw     = pow_arr[dim_idx[pief_pkg::DIDX_W-1:0]];
  assign pw         = (32'(pw_raw) > pief_pkg::MAX_POWER) ?
                      pief_pkg::POW_W'(pief_pkg::MAX_POWER) : pw_raw;
  assign terms_done = (term_idx == n_terms);
  assign dims_done  = (dim_idx == pief_pkg::DCNT_W'(pief_pkg::SPACE_DIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pief_pkg::ST_IDLE;
      term_idx <= '0;
      dim_idx  <= '0;
      pcnt     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        pief_pkg::ST_IDLE:  term_idx <= '0;
        pief_pkg::ST_TERM:  dim_idx  <= '0;
        pief_pkg::ST_DIM:   pcnt     <= pw;
        pief_pkg::ST_STEP: begin
          if (pcnt == '0) dim_idx <= dim_idx + 1'b1;
        end
        pief_pkg::ST_FOLD:  pcnt     <= pcnt - 1'b1;
        pief_pkg::ST_ACCUM: term_idx <= term_idx + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pief_pkg::ST_IDLE:   if (start) state_next = pief_pkg::ST_TERM;
      pief_pkg::ST_TERM:   state_next = terms_done ? pief_pkg::ST_NEGATE : pief_pkg::ST_DIM;
      pief_pkg::ST_DIM:    state_next = dims_done ? pief_pkg::ST_ACCUM : pief_pkg::ST_STEP;
      pief_pkg::ST_STEP:   state_next = (pcnt == '0) ? pief_pkg::ST_DIM : pief_pkg::ST_MUL_LO;
      pief_pkg::ST_MUL_LO: state_next = pief_pkg::ST_MUL_HI;
      pief_pkg::ST_MUL_HI: state_next = pief_pkg::ST_FOLD;
      pief_pkg::ST_FOLD:   state_next = pief_pkg::ST_STEP;
      pief_pkg::ST_ACCUM:  state_next = pief_pkg::ST_TERM;
      pief_pkg::ST_NEGATE: state_next = pief_pkg::ST_DONE;
      pief_pkg::ST_DONE:   state_next = pief_pkg::ST_IDLE;
      default:             state_next = pief_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.term_sel = term_idx[pief_pkg::TIDX_W-1:0];
    cmd.dim_sel  = dim_idx[pief_pkg::DIDX_W-1:0];
    busy         = 1'b1;
    done         = 1'b0;
    unique case (state)
      pief_pkg::ST_IDLE: begin
        busy           = 1'b0;
        cmd.load_point = start;
      end
      pief_pkg::ST_TERM:   cmd.load_coef = ~terms_done;
      pief_pkg::ST_MUL_LO: cmd.mul_lo    = 1'b1;
      pief_pkg::ST_MUL_HI: cmd.mul_hi    = 1'b1;
      pief_pkg::ST_FOLD:   cmd.fold      = 1'b1;
      pief_pkg::ST_ACCUM:  cmd.accum     = 1'b1;
      pief_pkg::ST_NEGATE: cmd.negate    = 1'b1;
      pief_pkg::ST_DONE:   done          = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/pief_dpath.sv =====
// Datapath: point registers, running term value, sum and overflow flag,
// one shared 25x32 multiplier used twice per Q16.16 multiply.
// Depends on pief_pkg for widths, limits, cmd_t and cfg_t.
module pief_dpath (
  input  logic                                  clk,
  input  pief_pkg::cmd_t                        cmd,
  input  pief_pkg::cfg_t                        cfg,
  input  logic signed [pief_pkg::COORD_W-1:0]   point_x,
  input  logic signed [pief_pkg::COORD_W-1:0]   point_y,
  input  logic signed [pief_pkg::COORD_W-1:0]   point_z,
  output logic signed [pief_pkg::VAL_W-1:0]     func_value,
  output logic                                  overflow
);

  logic signed [pief_pkg::COORD_W-1:0] pt [pief_pkg::SPACE_DIM];
  logic signed [pief_pkg::VAL_W-1:0]   cur;
  logic signed [pief_pkg::VAL_W-1:0]   sum;
  logic                                ovf;
  logic signed [pief_pkg::PART_W-1:0]  mul_r;
  logic signed [pief_pkg::PART_W-1:0]  lo_r;

  logic signed [pief_pkg::COORD_W-1:0]  coord;
  logic signed [pief_pkg::COORD_W-1:0]  coef;
  logic signed [pief_pkg::HALF_W:0]     mul_a;
  logic signed [pief_pkg::PART_W-1:0]   mul_p;
  logic signed [pief_pkg::FULL_W-1:0]   full;
  logic        [pief_pkg::SHR_W-1:0]    shr;
  logic        [pief_pkg::SHR_W-pief_pkg::VAL_W:0] shr_top;
  logic                                 fold_fits;
  logic        [pief_pkg::VAL_W-1:0]    fold_val;
  logic        [pief_pkg::VAL_W:0]      add_w;
  logic        [pief_pkg::VAL_W:0]      neg_w;
  logic        [pief_pkg::VAL_W-1:0]    add_val;
  logic        [pief_pkg::VAL_W-1:0]    neg_val;

  assign coord = pt[cmd.dim_sel];
  assign coef  = $signed(cfg.term_word[cmd.term_sel][pief_pkg::COORD_W-1:0]);

  // low half is unsigned, high half carries the sign
  assign mul_a = cmd.mul_lo ?
                 $signed({1'b0, cur[pief_pkg::HALF_W-1:0]}) :
                 $signed({cur[pief_pkg::VAL_W-1], cur[pief_pkg::VAL_W-1:pief_pkg::HALF_W]});
  assign mul_p = mul_a * coord;

  // full product = lo + (hi << 24); keep bits above the fraction (floor)
  assign full      = pief_pkg::FULL_W'(lo_r) +
                     (pief_pkg::FULL_W'(mul_r) <<< pief_pkg::HALF_W);
  assign shr       = full[pief_pkg::FULL_W-1:pief_pkg::FRAC_W];
  assign shr_top   = shr[pief_pkg::SHR_W-1:pief_pkg::VAL_W-1];
  assign fold_fits = (&shr_top) | ~(|shr_top);
  assign fold_val  = fold_fits ? shr[pief_pkg::VAL_W-1:0] :
                     (shr[pief_pkg::SHR_W-1] ? pief_pkg::VAL_MIN : pief_pkg::VAL_MAX);

  assign add_w   = {sum[pief_pkg::VAL_W-1], sum} + {cur[pief_pkg::VAL_W-1], cur};
  assign add_val = (add_w[pief_pkg::VAL_W] == add_w[pief_pkg::VAL_W-1]) ?
                   add_w[pief_pkg::VAL_W-1:0] :
                   (add_w[pief_pkg::VAL_W] ? pief_pkg::VAL_MIN : pief_pkg::VAL_MAX);
  assign neg_w   = '0 - {sum[pief_pkg::VAL_W-1], sum};
  assign neg_val = (neg_w[pief_pkg::VAL_W] == neg_w[pief_pkg::VAL_W-1]) ?
                   neg_w[pief_pkg::VAL_W-1:0] :
                   (neg_w[pief_pkg::VAL_W] ? pief_pkg::VAL_MIN : pief_pkg::VAL_MAX);

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      pt[0] <= point_x;
      pt[1] <= point_y;
      if (pief_pkg::SPACE_DIM > 2) pt[pief_pkg::SPACE_DIM-1] <= point_z;
      sum <= '0;
      ovf <= 1'b0;
    end
    if (cmd.load_coef) cur <= pief_pkg::VAL_W'(coef);
    if (cmd.mul_lo) mul_r <= mul_p;
    if (cmd.mul_hi) begin
      lo_r  <= mul_r;
      mul_r <= mul_p;
    end
    if (cmd.fold) begin
      cur <= fold_val;
      if (!fold_fits) ovf <= 1'b1;
    end
    if (cmd.accum) begin
      sum <= add_val;
      if (add_w[pief_pkg::VAL_W] != add_w[pief_pkg::VAL_W-1]) ovf <= 1'b1;
    end
    if (cmd.negate && !cfg.inside_flag) begin
      sum <= neg_val;
      if (neg_w[pief_pkg::VAL_W] != neg_w[pief_pkg::VAL_W-1]) ovf <= 1'b1;
    end
  end

  assign func_value = sum;
  assign overflow   = ovf;

endmodule

// ===== hw/rtl/pief_checker.sv =====
// Port-level checks on the start/busy/done sequencing of the evaluator.
// Bound to polynomial_implicit_function_eval; no package dependency.
module pief_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // the result strobe only comes while an item is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted item");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("block not idle after result");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result in the cycle after acceptance");

  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!busy && !done))
    else $error("not idle after reset");

endmodule

bind polynomial_implicit_function_eval pief_checker u_pief_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== sim/polynomial_implicit_function_eval_tb.sv =====
// Self-checking testbench for polynomial_implicit_function_eval.
// Predicts each point's Q32.16 polynomial value and overflow flag, then checks every
// done strobe against it. Uses pief_pkg only.
`timescale 1ns / 100ps

module polynomial_implicit_function_eval_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_ITEMS   = 1300;

  localparam logic signed [pief_pkg::FULL_W-1:0] WIDE_MAX =
    {{(pief_pkg::FULL_W-pief_pkg::VAL_W){1'b0}}, pief_pkg::VAL_MAX};
  localparam logic signed [pief_pkg::FULL_W-1:0] WIDE_MIN =
    {{(pief_pkg::FULL_W-pief_pkg::VAL_W){1'b1}}, pief_pkg::VAL_MIN};

  localparam logic [pief_pkg::COORD_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [pief_pkg::COORD_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [pief_pkg::COORD_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [pief_pkg::COORD_W-1:0] Q_MIN     = 32'h8000_0000;

  typedef struct packed {
    logic signed [pief_pkg::VAL_W-1:0] value;
    logic                              ovf;
  } poly_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic signed [pief_pkg::COORD_W-1:0]  point_x = '0;
  logic signed [pief_pkg::COORD_W-1:0]  point_y = '0;
  logic signed [pief_pkg::COORD_W-1:0]  point_z = '0;
  logic                                 done;
  logic signed [pief_pkg::VAL_W-1:0]    func_value;
  logic                                 overflow;
  logic                                 psel = 1'b0;
  logic                                 penable = 1'b0;
  logic                                 pwrite = 1'b0;
  logic [pief_pkg::ADDR_W-1:0]          paddr = '0;
  logic [pief_pkg::DATA_W-1:0]          pwdata = '0;
  logic [pief_pkg::DATA_W-1:0]          prdata;
  logic                                 pready;

  pief_pkg::cfg_t              shadow_cfg;
  poly_result_t                expected_values[$];
  logic [pief_pkg::TERM_W-1:0] plan_terms[pief_pkg::NUM_TERM_REGS];
  int                          mismatch_count = 0;
  int                          idle_cycles = 0;
  int                          burst_left = 0;
  bit                          start_high = 1'b0;

  polynomial_implicit_function_eval dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .done(done), .func_value(func_value), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- prediction ----------------

  function automatic poly_result_t fit48(input logic signed [pief_pkg::FULL_W-1:0] v);
    poly_result_t r;
    r.ovf = 1'b0;
    if (v > WIDE_MAX) begin
      r.value = pief_pkg::VAL_MAX;
      r.ovf = 1'b1;
    end else if (v < WIDE_MIN) begin
      r.value = pief_pkg::VAL_MIN;
      r.ovf = 1'b1;
    end else begin
      r.value = v[pief_pkg::VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic poly_result_t eval_polynomial(
      input pief_pkg::cfg_t cfg,
      input logic signed [pief_pkg::COORD_W-1:0] x,
      input logic signed [pief_pkg::COORD_W-1:0] y,
      input logic signed [pief_pkg::COORD_W-1:0] z);
    logic signed [pief_pkg::FULL_W-1:0]  pt[3];
    logic signed [pief_pkg::FULL_W-1:0]  cur;
    logic signed [pief_pkg::FULL_W-1:0]  sum;
    logic signed [pief_pkg::FULL_W-1:0]  prod;
    logic signed [pief_pkg::COORD_W-1:0] coef;
    logic [pief_pkg::TERM_W-1:0]         w;
    logic [pief_pkg::POW_W-1:0]          pw;
    poly_result_t                        r;
    poly_result_t                        res;
    int                                  n;
    pt[0] = x;
    pt[1] = y;
    pt[2] = z;
    sum = '0;
    res.ovf = 1'b0;
    n = (cfg.term_count > pief_pkg::MAX_TERMS) ? pief_pkg::MAX_TERMS : int'(cfg.term_count);
    for (int t = 0; t < n; t++) begin
      w = cfg.term_word[t];
      coef = w[pief_pkg::COORD_W-1:0];
      cur = coef;
      for (int d = 0; d < pief_pkg::SPACE_DIM; d++) begin
        pw = w[pief_pkg::COORD_W + pief_pkg::POW_W*d +: pief_pkg::POW_W];
        if (pw > pief_pkg::MAX_POWER) pw = pief_pkg::POW_W'(pief_pkg::MAX_POWER);
        for (int k = 0; k < pw; k++) begin
          prod = cur * pt[d];
          r = fit48(prod >>> pief_pkg::FRAC_W);
          res.ovf |= r.ovf;
          cur = signed'(r.value);
        end
      end
      r = fit48(sum + cur);
      res.ovf |= r.ovf;
      sum = signed'(r.value);
    end
    if (!cfg.inside_flag) begin
      r = fit48(-sum);
      res.ovf |= r.ovf;
      sum = signed'(r.value);
    end
    res.value = sum[pief_pkg::VAL_W-1:0];
    return res;
  endfunction

  function automatic logic [pief_pkg::DATA_W-1:0] shadow_reg(
      input logic [pief_pkg::REG_IDX_W-1:0] idx);
    if (idx == pief_pkg::REG_INSIDE) return pief_pkg::DATA_W'(shadow_cfg.inside_flag);
    if (idx == pief_pkg::REG_COUNT) return pief_pkg::DATA_W'(shadow_cfg.term_count);
    return pief_pkg::DATA_W'(shadow_cfg.term_word[idx - pief_pkg::REG_TERM0]);
  endfunction

  // ---------------- result checking ----------------

  task automatic note_mismatch(input string what, input logic [pief_pkg::DATA_W-1:0] exp_v,
                               input logic [pief_pkg::DATA_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    poly_result_t exp_r;
    if (!rst && done) begin
      if (expected_values.size() == 0) begin
        note_mismatch("unexpected result", '0, pief_pkg::DATA_W'(func_value));
      end else begin
        exp_r = expected_values.pop_front();
        if (func_value !== exp_r.value)
          note_mismatch("func_value", pief_pkg::DATA_W'(exp_r.value),
                        pief_pkg::DATA_W'(func_value));
        if (overflow !== exp_r.ovf)
          note_mismatch("overflow", pief_pkg::DATA_W'(exp_r.ovf),
                        pief_pkg::DATA_W'(overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || psel || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- register port ----------------

  task automatic reg_write(input logic [pief_pkg::REG_IDX_W-1:0] idx,
                           input logic [pief_pkg::DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      pief_pkg::REG_INSIDE: shadow_cfg.inside_flag = data[0];
      pief_pkg::REG_COUNT:  shadow_cfg.term_count = data[pief_pkg::CNT_W-1:0];
      default: shadow_cfg.term_word[idx - pief_pkg::REG_TERM0] = data[pief_pkg::TERM_W-1:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [pief_pkg::REG_IDX_W-1:0] idx);
    logic [pief_pkg::DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    if (got !== shadow_reg(idx)) note_mismatch("register read", shadow_reg(idx), got);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // writes every register from plan_terms plus the two control fields
  task automatic load_setup(input logic keep_sign, input logic [pief_pkg::CNT_W-1:0] count);
    reg_write(pief_pkg::REG_INSIDE, pief_pkg::DATA_W'(keep_sign));
    reg_write(pief_pkg::REG_COUNT, pief_pkg::DATA_W'(count));
    for (int i = 0; i < pief_pkg::NUM_TERM_REGS; i++)
      reg_write(pief_pkg::REG_TERM0 + pief_pkg::REG_IDX_W'(i),
                pief_pkg::DATA_W'(plan_terms[i]));
  endtask

  function automatic logic [pief_pkg::TERM_W-1:0] term(
      input logic [pief_pkg::COORD_W-1:0] coef, input int px, input int py, input int pz);
    return {pief_pkg::POW_W'(pz), pief_pkg::POW_W'(py), pief_pkg::POW_W'(px), coef};
  endfunction

  // ---------------- point stimulus ----------------

  task automatic drop_start();
    if (start_high) begin
      start <= 1'b0;
      start_high = 1'b0;
    end
  endtask

  task automatic send_point(input logic [pief_pkg::COORD_W-1:0] x,
                            input logic [pief_pkg::COORD_W-1:0] y,
                            input logic [pief_pkg::COORD_W-1:0] z);
    start <= 1'b1;
    start_high = 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_values.push_back(eval_polynomial(shadow_cfg, x, y, z));
  endtask

  // bursts of back-to-back items, random gaps between bursts
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    drop_start();
    gap = $urandom_range(1, 12);
    if ($urandom_range(0, 1)) begin
      @(posedge clk);
      while (busy) @(posedge clk);
    end
    repeat (gap) @(posedge clk);
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
  endtask

  // block goes quiet only once the last expected result has come back
  task automatic wait_idle();
    drop_start();
    @(posedge clk);
    while (expected_values.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [pief_pkg::COORD_W-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return Q_ONE;
      3: return Q_NEG_ONE;
      4: return 32'h0000_0001;
      5: return 32'hFFFF_FFFF;
      default: return '0;
    endcase
  endfunction

  function automatic logic [pief_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return pick_extreme();
      default: return pief_pkg::COORD_W'($urandom_range(0, 1 << 19)) -
                      pief_pkg::COORD_W'(1 << 18);
    endcase
  endfunction

  function automatic logic [pief_pkg::TERM_W-1:0] pick_term();
    logic [pief_pkg::COORD_W-1:0] coef;
    int                           pw[3];
    case ($urandom_range(0, 7))
      0: coef = $urandom();
      1: coef = pick_extreme();
      default: coef = pief_pkg::COORD_W'($urandom_range(0, 1 << 20)) -
                      pief_pkg::COORD_W'(1 << 19);
    endcase
    for (int d = 0; d < 3; d++)
      pw[d] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, pief_pkg::MAX_POWER) :
                                            $urandom_range(0, 3);
    return term(coef, pw[0], pw[1], pw[2]);
  endfunction

  // ---------------- tests ----------------

  task automatic test_reset_state();
    for (int i = 0; i < pief_pkg::NUM_REGS; i++) reg_check(pief_pkg::REG_IDX_W'(i));
    send_point(Q_MAX, Q_MIN, Q_ONE);
    send_point('0, '0, '0);
    wait_idle();
  endtask

  task automatic test_register_access();
    for (int i = 0; i < pief_pkg::NUM_REGS; i++) begin
      reg_write(pief_pkg::REG_IDX_W'(i), '1);
      reg_check(pief_pkg::REG_IDX_W'(i));
    end
    for (int i = 0; i < pief_pkg::NUM_REGS; i++) begin
      reg_write(pief_pkg::REG_IDX_W'(i), {$urandom(), $urandom()});
      reg_check(pief_pkg::REG_IDX_W'(i));
    end
  endtask

  task automatic test_power_cases();
    // zero powers everywhere: the factor is one even at the origin
    for (int i = 0; i < pief_pkg::NUM_TERM_REGS; i++) plan_terms[i] = '0;
    plan_terms[0] = term(32'h0001_8000, 0, 0, 0);
    load_setup(1'b1, 3'd1);
    send_point('0, '0, '0);
    wait_idle();

    plan_terms[0] = term(Q_ONE, 1, 1, 1);
    load_setup(1'b1, 3'd1);
    send_point(Q_MAX, Q_MIN, Q_ONE);
    send_point(Q_MIN, Q_MIN, Q_MIN);
    wait_idle();

    // highest power on each axis
    plan_terms[0] = term(Q_ONE, pief_pkg::MAX_POWER, 0, 0);
    plan_terms[1] = term(Q_ONE, 0, pief_pkg::MAX_POWER, 0);
    plan_terms[2] = term(Q_ONE, 0, 0, pief_pkg::MAX_POWER);
    load_setup(1'b1, 3'd3);
    send_point(Q_NEG_ONE, 32'h0002_0000, '0);
    send_point(Q_MAX, Q_NEG_ONE, 32'h0000_8000);
    send_point('0, '0, Q_MIN);
    wait_idle();

    // truncation rounds toward minus infinity
    plan_terms[0] = term(32'hFFFF_FFFF, 1, 0, 0);
    load_setup(1'b1, 3'd1);
    send_point(32'h0000_8000, Q_ONE, Q_ONE);
    wait_idle();
  endtask

  task automatic test_term_count_and_saturation();
    // count above the number of terms is capped
    for (int i = 0; i < pief_pkg::NUM_TERM_REGS; i++) plan_terms[i] = term(Q_ONE, 0, 0, 0);
    load_setup(1'b1, 3'd7);
    send_point(Q_MAX, Q_MAX, Q_MAX);
    wait_idle();
    for (int i = 0; i < pief_pkg::NUM_TERM_REGS; i++) plan_terms[i] = '1;
    load_setup(1'b1, 3'd6);
    send_point(Q_NEG_ONE, Q_ONE, Q_NEG_ONE);
    wait_idle();

    // every term saturates high, then the sum saturates too
    for (int i = 0; i < pief_pkg::NUM_TERM_REGS; i++)
      plan_terms[i] = term(Q_MAX, pief_pkg::MAX_POWER, 0, 0);
    load_setup(1'b1, 3'd6);
    send_point(Q_MAX, '0, '0);
    wait_idle();

    // most negative value negated
    for (int i = 0; i < pief_pkg::NUM_TERM_REGS; i++) plan_terms[i] = '0;
    plan_terms[0] = term(Q_MIN, pief_pkg::MAX_POWER, 0, 0);
    load_setup(1'b0, 3'd1);
    send_point(Q_MAX, '0, '0);
    plan_terms[0] = term(32'h0003_0000, 1, 1, 0);
    wait_idle();
    load_setup(1'b0, 3'd1);
    send_point(32'h0002_0000, 32'hFFFE_8000, Q_ONE);
    wait_idle();
  endtask

  task automatic test_random_points();
    int left;
    int chunk;
    logic [pief_pkg::CNT_W-1:0] count;
    left = RANDOM_ITEMS;
    while (left > 0) begin
      for (int i = 0; i < pief_pkg::NUM_TERM_REGS; i++) plan_terms[i] = pick_term();
      case ($urandom_range(0, 9))
        0: count = '0;
        1: count = 3'd7;
        default: count = pief_pkg::CNT_W'($urandom_range(1, pief_pkg::MAX_TERMS));
      endcase
      load_setup(1'($urandom_range(0, 1)), count);
      chunk = $urandom_range(20, 70);
      if (chunk > left) chunk = left;
      burst_left = 0;
      for (int i = 0; i < chunk; i++) begin
        send_point(pick_coord(), pick_coord(), pick_coord());
        pace();
      end
      left -= chunk;
      wait_idle();
    end
  endtask

  initial begin
    shadow_cfg = '0;
    shadow_cfg.inside_flag = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_register_access();
    test_power_cases();
    test_term_count_and_saturation();
    test_random_points();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_values.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
